[hdl/multichannel_step_tone_generator_top_assert.svh]
// Assertion macros shared by the step tone generator modules.
// Expects clk and rst_n in the scope of each use.
`ifndef MULTICHANNEL_STEP_TONE_GENERATOR_TOP_ASSERT_SVH
`define MULTICHANNEL_STEP_TONE_GENERATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define MSTG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MSTG_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/mstg_pkg.sv]
// Shared constants and control/status types for the step tone generator.
// No dependencies; used by the controller, the datapath and the top level.
package mstg_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam int ACTION_W  = 2;
    localparam int CHAN_W    = 3;
    localparam int PERIOD_W  = 16;
    localparam int POS_W     = 8;
    localparam int LEVEL_W   = 8;

    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [POS_W-1:0] MAX_POS_RESET = 8'd158;

    // Action codes
    localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_SET   = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RESET = 2'd2;

    // Register indexes
    localparam logic [0:0] REG_TURN_LIMIT = 1'b0;

    typedef struct packed {
        logic load;      // capture the input transaction
        logic apply;     // execute a set-period or reset command
        logic visit;     // update the channel under the walk pointer
        logic out_load;  // move the levels into the output register
    } mstg_cmd_t;

    typedef struct packed {
        logic in_tick;     // offered input is a tick
        logic last_visit;  // walk pointer sits on the last channel
        logic out_busy;    // output register holds an untaken result
    } mstg_status_t;

endpackage

[hdl/mstg_ctrl.sv]
// Sequencer for the step tone generator: accepts transactions, walks the
// channels on a tick and hands the result to the output register. Uses mstg_pkg.
`include "multichannel_step_tone_generator_top_assert.svh"

module mstg_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  mstg_pkg::mstg_status_t status,
    output mstg_pkg::mstg_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_APPLY  = 4'b0010,
        ST_WALK   = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready     = (state_reg == ST_IDLE);
    assign cmd.load     = s_tvalid && s_tready;
    assign cmd.apply    = (state_reg == ST_APPLY);
    assign cmd.visit    = (state_reg == ST_WALK);
    assign cmd.out_load = (state_reg == ST_FINISH) && !status.out_busy;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = status.in_tick ? ST_WALK : ST_APPLY;
                end
            end
            ST_APPLY:
            begin
                state_next = ST_FINISH;
            end
            ST_WALK:
            begin
                if (status.last_visit)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                // hold until the previous result has been taken
                if (!status.out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    `MSTG_ASSERT_NEXT(a_tick_starts_walk, cmd.load && status.in_tick, state_reg == ST_WALK, "tick did not start a channel walk")
    `MSTG_ASSERT_NEXT(a_walk_ends_in_finish, (state_reg == ST_WALK) && status.last_visit, state_reg == ST_FINISH, "walk overran the last channel")

endmodule

[hdl/mstg_datapath.sv]
// Channel state, per-channel step logic and output register of the step
// tone generator. Driven by mstg_ctrl; uses mstg_pkg.
`include "multichannel_step_tone_generator_top_assert.svh"

module mstg_datapath
#(
    parameter int CHANNELS = mstg_pkg::CHANNELS_DEF,
    parameter int IDX_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  mstg_pkg::mstg_cmd_t                 cmd,
    output mstg_pkg::mstg_status_t              status,
    input  logic [mstg_pkg::IN_TDATA_W-1:0]     s_tdata,
    input  logic [mstg_pkg::POS_W-1:0]          turn_limit,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mstg_pkg::OUT_TDATA_W-1:0]    m_tdata
);

    localparam int PW = mstg_pkg::PERIOD_W;
    localparam int QW = mstg_pkg::POS_W;
    localparam int LW = mstg_pkg::LEVEL_W;

    // captured transaction
    logic [mstg_pkg::ACTION_W-1:0] act_reg;
    logic [mstg_pkg::CHAN_W-1:0]   chan_reg;
    logic [PW-1:0]                 period_in_reg;

    // per-channel state
    logic [PW-1:0] period_reg [CHANNELS];
    logic [PW-1:0] count_reg  [CHANNELS];
    logic [QW-1:0] pos_reg    [CHANNELS];
    logic [CHANNELS-1:0] rev_reg;
    logic [CHANNELS-1:0] step_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [LW-1:0]    stepped_reg;
    logic [LW-1:0]    stepped_next;

    logic                          m_tvalid_reg;
    logic [mstg_pkg::OUT_TDATA_W-1:0] m_tdata_reg;

    logic [PW-1:0] cur_period;
    logic [PW-1:0] cur_count;
    logic [QW-1:0] cur_pos;
    logic          cur_rev;
    logic [PW-1:0] count_inc;
    logic          active;
    logic          hit;
    logic          rev_new;
    logic [QW-1:0] pos_new;
    logic          chan_ok;
    logic [IDX_W-1:0] chan_idx;

    logic [LW-1:0] step_levels;
    logic [LW-1:0] dir_levels;

    assign status.in_tick    = (s_tdata[mstg_pkg::ACTION_W-1:0] == mstg_pkg::ACT_TICK);
    assign status.last_visit = (idx_reg == IDX_W'(CHANNELS - 1));
    assign status.out_busy   = m_tvalid_reg && !m_tready;

    assign cur_period = period_reg[idx_reg];
    assign cur_count  = count_reg[idx_reg];
    assign cur_pos    = pos_reg[idx_reg];
    assign cur_rev    = rev_reg[idx_reg];

    assign count_inc = cur_count + PW'(1);
    assign active    = (cur_period != '0);
    assign hit       = active && (count_inc >= cur_period);

    // reverse at or past the end stop, forward again at home
    always_comb
    begin
        priority if (cur_pos >= turn_limit)
        begin
            rev_new = 1'b1;
        end
        else if (cur_pos == '0)
        begin
            rev_new = 1'b0;
        end
        else
        begin
            rev_new = cur_rev;
        end
    end

    assign pos_new  = rev_new ? (cur_pos - QW'(1)) : (cur_pos + QW'(1));
    assign chan_ok  = (32'(chan_reg) < 32'(CHANNELS));
    assign chan_idx = IDX_W'(chan_reg);

    always_comb
    begin
        stepped_next = stepped_reg;
        for (int c = 0; c < LW; c++)
        begin
            if (cmd.visit && hit && (32'(idx_reg) == c))
            begin
                stepped_next[c] = 1'b1;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < LW; g++)
        begin : g_levels
            if (g < CHANNELS)
            begin : g_used
                assign step_levels[g] = step_reg[g];
                assign dir_levels[g]  = rev_reg[g];
            end
            else
            begin : g_unused
                assign step_levels[g] = 1'b0;
                assign dir_levels[g]  = 1'b0;
            end
        end
    endgenerate

    // input capture and output data, payload only
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg       <= s_tdata[1:0];
            chan_reg      <= s_tdata[4:2];
            period_in_reg <= s_tdata[20:5];
        end
        if (cmd.out_load)
        begin
            m_tdata_reg <= {stepped_reg, dir_levels, step_levels};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                period_reg[c] <= '0;
                count_reg[c]  <= '0;
                pos_reg[c]    <= '0;
            end
            rev_reg      <= '0;
            step_reg     <= '0;
            idx_reg      <= '0;
            stepped_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg     <= '0;
                stepped_reg <= '0;
            end
            else
            begin
                stepped_reg <= stepped_next;
            end

            if (cmd.visit)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
                if (active)
                begin
                    count_reg[idx_reg] <= hit ? '0 : count_inc;
                end
                if (hit)
                begin
                    pos_reg[idx_reg]  <= pos_new;
                    rev_reg[idx_reg]  <= rev_new;
                    step_reg[idx_reg] <= ~step_reg[idx_reg];
                end
            end

            if (cmd.apply)
            begin
                if (act_reg == mstg_pkg::ACT_SET)
                begin
                    if (chan_ok)
                    begin
                        period_reg[chan_idx] <= period_in_reg;
                    end
                end
                else if (act_reg == mstg_pkg::ACT_RESET)
                begin
                    // tick counts survive a reset command
                    for (int c = 0; c < CHANNELS; c++)
                    begin
                        period_reg[c] <= '0;
                        pos_reg[c]    <= '0;
                    end
                    rev_reg  <= '0;
                    step_reg <= '0;
                end
            end

            if (cmd.out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    `MSTG_ASSERT_NOW(a_visit_in_range, cmd.visit, 32'(idx_reg) < 32'(CHANNELS), "walk pointer beyond last channel")
    `MSTG_ASSERT_NEXT(a_reset_clears_levels, cmd.out_load && (act_reg == mstg_pkg::ACT_RESET), (m_tdata_reg[7:0] == '0) && (m_tdata_reg[23:16] == '0), "reset command left step levels or steps set")

endmodule

[hdl/multichannel_step_tone_generator_top.sv]
// Usage:
//   Slave stream (s_tvalid/s_tready/s_tdata) carries commands: tick, set a
//   channel's period, or reset all channels. Every accepted transaction
//   yields exactly one master-stream transaction (m_tvalid/m_tready/m_tdata)
//   with the step levels, direction levels and the mask of channels that
//   stepped on that command (nonzero only for ticks).
//   A tick walks the channels one per cycle through a single count/compare
//   unit; the finish state then moves the result into the output register
//   and the sequencer returns to idle, the only state in which a command is
//   taken, so a new command waits until the last one is through. Set and
//   reset commands pass through the apply and finish states instead.
//   The output register decouples the two sides: while a result waits,
//   the next command is still accepted and processed; its result is held
//   back in the finish state until the waiting one is taken.
//   The APB port holds the turn-around position at byte address 0 (reset
//   value 158); write it only while the block is idle.
//   rst_n clears all periods, counts, positions, directions and step levels
//   and empties the output register. There is no clearing pass.
// Depends on mstg_pkg, mstg_ctrl, mstg_datapath.
`include "multichannel_step_tone_generator_top_assert.svh"

module multichannel_step_tone_generator_top
#(
    parameter int CHANNELS = mstg_pkg::CHANNELS_DEF
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    // APB configuration
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mstg_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [mstg_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [mstg_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                 pready,
    // command stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mstg_pkg::IN_TDATA_W-1:0]      s_tdata,  // action[1:0], channel[4:2], period[20:5], zero pad
    // result stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mstg_pkg::OUT_TDATA_W-1:0]     m_tdata   // step_levels[7:0], direction_levels[15:8], stepped_mask[23:16]
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    logic [mstg_pkg::POS_W-1:0] turn_limit_reg;
    logic                       cfg_write;
    logic                       cfg_sel_max;

    mstg_pkg::mstg_cmd_t    cmd;
    mstg_pkg::mstg_status_t status;

    assign pready      = 1'b1;
    assign cfg_sel_max = (paddr[2] == mstg_pkg::REG_TURN_LIMIT);
    assign cfg_write   = psel && penable && pwrite && pready;

    always_comb
    begin
        prdata = '0;
        if (cfg_sel_max)
        begin
            prdata = mstg_pkg::CFG_DATA_W'(turn_limit_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_limit_reg <= mstg_pkg::MAX_POS_RESET;
        end
        else if (cfg_write && cfg_sel_max)
        begin
            turn_limit_reg <= pwdata[mstg_pkg::POS_W-1:0];
        end
    end

    mstg_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mstg_datapath
    #(
        .CHANNELS (CHANNELS),
        .IDX_W    (IDX_W)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .s_tdata      (s_tdata),
        .turn_limit   (turn_limit_reg),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

    `MSTG_ASSERT_NOW(a_no_accept_while_busy, s_tvalid && s_tready, !cmd.visit && !cmd.apply, "command accepted while another is in progress")

endmodule
